// ===== sv/plpa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpa_pkg: shared definitions for the positional letter profile core
// Field widths, mode codes and the control groups passed between modules.
// ----------------------------------------------------------------------------
package plpa_pkg;

  // Fixed item field widths
  localparam int MODE_W    = 2;
  localparam int LETTERS_W = 25;
  localparam int CODE_W    = 5;
  localparam int ID_W      = 12;
  localparam int SCORE_W   = 15;

  // Slave-side tdata padded to whole bytes
  localparam int IN_DATA_W  = ((LETTERS_W + ID_W + 7) / 8) * 8;
  // Master-side tdata padded to whole bytes
  localparam int OUT_DATA_W = ((ID_W + SCORE_W + 7) / 8) * 8;

  // Largest reportable score
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  // Parameter defaults
  localparam int WORD_LEN_DEF  = 5;
  localparam int ALPHABET_DEF  = 26;
  localparam int MAX_WORDS_DEF = 4096;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COUNT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCORE = 2'd2;

  // Per-lane strobes, already qualified by the input handshake
  typedef struct packed {
    logic clear;
    logic count;
    logic lookup;
  } lane_ctrl_t;

  // Item held in front of the merge stage
  typedef struct packed {
    logic valid;
    logic clear;
    logic score;
    logic last;
  } merge_ctrl_t;

endpackage

// ===== sv/plpa_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpa_lane: letter histogram for one word position
// Holds one saturating counter per letter, clears them on clear items, bumps
// one on count items, registers the looked-up letter's count on score items.
// ----------------------------------------------------------------------------
module plpa_lane #(
  parameter int ALPHABET  = plpa_pkg::ALPHABET_DEF,
  parameter int MAX_WORDS = plpa_pkg::MAX_WORDS_DEF,
  parameter int CNT_W     = $clog2(MAX_WORDS + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  plpa_pkg::lane_ctrl_t        ctrl,
  input  logic [plpa_pkg::CODE_W-1:0] code,
  output logic [CNT_W-1:0]            count_q
);

  localparam int AW = $clog2(ALPHABET);

  logic [CNT_W-1:0] counts [ALPHABET];
  logic             in_alpha;
  logic [AW-1:0]    idx;
  logic [CNT_W-1:0] cur;

  // Decode the letter; codes past the alphabet touch nothing
  assign in_alpha = ({1'b0, code} < (plpa_pkg::CODE_W + 1)'(ALPHABET));
  assign idx      = code[AW-1:0];
  assign cur      = in_alpha ? counts[idx] : '0;

  // Clear all counters at once, or bump one with saturation
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      counts <= '{default: '0};
    end else if (ctrl.count && in_alpha && (counts[idx] < CNT_W'(MAX_WORDS))) begin
      counts[idx] <= counts[idx] + CNT_W'(1);
    end
  end

  // Capture the looked-up count for the merge stage
  always_ff @(posedge clk) begin
    if (ctrl.lookup) begin
      count_q <= cur;
    end
  end

endmodule

// ===== sv/plpa_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpa_merge: sum the lane counts and track the best candidate
// Adds the per-position counts, saturates the score, keeps the first
// strictly highest candidate and loads the result register on the last item.
// ----------------------------------------------------------------------------
module plpa_merge #(
  parameter int WORD_LEN = plpa_pkg::WORD_LEN_DEF,
  parameter int CNT_W    = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  plpa_pkg::merge_ctrl_t         ctrl,
  input  logic [plpa_pkg::ID_W-1:0]     id,
  input  logic [WORD_LEN*CNT_W-1:0]     lane_counts,
  output logic                          adv,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [plpa_pkg::ID_W-1:0]     out_id,
  output logic [plpa_pkg::SCORE_W-1:0]  out_score,
  output logic                          out_found
);

  localparam int SUM_W = CNT_W + 3;

  logic [SUM_W-1:0]             sum;
  logic [plpa_pkg::SCORE_W-1:0] sat;
  logic [plpa_pkg::SCORE_W-1:0] best_score;
  logic [plpa_pkg::ID_W-1:0]    best_id;
  logic                         have_best;
  logic [plpa_pkg::SCORE_W-1:0] nb_score;
  logic [plpa_pkg::ID_W-1:0]    nb_id;
  logic                         nb_have;
  logic                         emit;

  // Add the lane counts and clamp to the score range
  always_comb begin
    sum = '0;
    for (int p = 0; p < WORD_LEN; p++) begin
      sum = sum + SUM_W'(lane_counts[p*CNT_W +: CNT_W]);
    end
    if (sum > SUM_W'(plpa_pkg::SCORE_MAX)) begin
      sat = plpa_pkg::SCORE_MAX;
    end else begin
      sat = sum[plpa_pkg::SCORE_W-1:0];
    end
  end

  // Replace the best only on a strictly higher score
  always_comb begin
    nb_score = best_score;
    nb_id    = best_id;
    nb_have  = have_best;
    if (sat > best_score) begin
      nb_score = sat;
      nb_id    = id;
      nb_have  = 1'b1;
    end
  end

  // Hold the item while its result cannot enter a full output register
  assign emit = ctrl.valid && ctrl.score && ctrl.last;
  assign adv  = !(emit && out_valid && !out_ready);

  // Best-so-far and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      best_score <= '0;
      best_id    <= '0;
      have_best  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // Load a new result, or drop the current one once it is taken
      if (emit && adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.valid && adv) begin
        if (ctrl.clear) begin
          best_score <= '0;
          best_id    <= '0;
          have_best  <= 1'b0;
        end else if (ctrl.score) begin
          if (ctrl.last) begin
            out_found  <= nb_have;
            out_id     <= nb_have ? nb_id : '0;
            out_score  <= nb_have ? nb_score : '0;
            best_score <= '0;
            best_id    <= '0;
            have_best  <= 1'b0;
          end else begin
            best_score <= nb_score;
            best_id    <= nb_id;
            have_best  <= nb_have;
          end
        end
      end
    end
  end

  // No pick means an all-zero result
  a_nopick_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_found |-> (out_id == '0) && (out_score == '0))
    else $error("result without a pick carries nonzero fields");

  // A pick always carries a nonzero score
  a_pick_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_found |-> (out_score != '0))
    else $error("picked candidate has zero score");

  // Without a best the stored score stays zero
  a_best_consistent: assert property (@(posedge clk) disable iff (rst)
    !have_best |-> (best_score == '0))
    else $error("best score set without a best candidate");

  // A last score item that advances shows a result next cycle
  a_emit_result: assert property (@(posedge clk) disable iff (rst)
    emit && adv |=> out_valid)
    else $error("last score item produced no result");

  // The merge stage stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !adv |-> out_valid && !out_ready && emit)
    else $error("merge stage stalled without cause");

endmodule

// ===== sv/positional_letter_profile_argmax_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_letter_profile_argmax_core: positional letter histogram scorer
// Counts words into a per-position letter profile and reports the first
// candidate with the highest profile score.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_* channel; s_tuser selects clear, count or score.
//   Count items add a word to the profile, score items rate a candidate, and
//   the score item with s_tlast set sends one result on the m_* channel.
//   One lane per word position holds that position's letter counters; all
//   lanes are updated or looked up in the cycle the item is accepted.
//   Throughput: one item per clock while s_tready is high. The lane lookup
//   register and the merge stage (lane sum, saturate, compare) form a
//   two-stage pipeline; m_tvalid rises when the last score item of a pass
//   has passed the lookup register and the merge stage loads its result.
//   A finished result waits in the output register while further items keep
//   flowing; only a second last score item stalls s_tready until m_tready
//   takes the pending result. Reset clears all counters and the best-so-far;
//   s_tready is low during reset and the block accepts items once it falls.
// ----------------------------------------------------------------------------
module positional_letter_profile_argmax_core #(
  parameter int WORD_LEN  = plpa_pkg::WORD_LEN_DEF,
  parameter int ALPHABET  = plpa_pkg::ALPHABET_DEF,
  parameter int MAX_WORDS = plpa_pkg::MAX_WORDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // word_letters[24:0], word_id[36:25], zero pad
  input  logic [plpa_pkg::IN_DATA_W-1:0]    s_tdata,
  // mode[1:0]
  input  logic [plpa_pkg::MODE_W-1:0]       s_tuser,
  input  logic                              s_tlast,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // best_word_id[11:0], best_score[26:12], zero pad
  output logic [plpa_pkg::OUT_DATA_W-1:0]   m_tdata,
  // found[0]
  output logic                              m_tuser
);

  localparam int CNT_W = $clog2(MAX_WORDS + 1);

  logic                              accept;
  logic [plpa_pkg::LETTERS_W-1:0]    letters;
  logic [plpa_pkg::ID_W-1:0]         in_id;
  plpa_pkg::lane_ctrl_t              lane_ctrl;
  plpa_pkg::merge_ctrl_t             a_ctrl;
  logic [plpa_pkg::ID_W-1:0]         a_id;
  logic [WORD_LEN*CNT_W-1:0]         lane_counts;
  logic                              adv;
  logic [plpa_pkg::ID_W-1:0]         out_id;
  logic [plpa_pkg::SCORE_W-1:0]      out_score;

  // Unpack the input item
  assign letters = s_tdata[plpa_pkg::LETTERS_W-1:0];
  assign in_id   = s_tdata[plpa_pkg::LETTERS_W +: plpa_pkg::ID_W];

  // Take a new item whenever the merge stage is free to move
  assign s_tready = !rst && (!a_ctrl.valid || adv);
  assign accept   = s_tvalid && s_tready;

  // Lane strobes
  assign lane_ctrl.clear  = accept && (s_tuser == plpa_pkg::MODE_CLEAR);
  assign lane_ctrl.count  = accept && (s_tuser == plpa_pkg::MODE_COUNT);
  assign lane_ctrl.lookup = accept && (s_tuser == plpa_pkg::MODE_SCORE);

  // One lane per word position; positions past the field read letter zero
  for (genvar p = 0; p < WORD_LEN; p++) begin : g_lane
    logic [plpa_pkg::CODE_W-1:0] code;
    if ((p + 1) * plpa_pkg::CODE_W <= plpa_pkg::LETTERS_W) begin : g_in_field
      assign code = letters[p*plpa_pkg::CODE_W +: plpa_pkg::CODE_W];
    end else begin : g_past_field
      assign code = '0;
    end
    plpa_lane #(
      .ALPHABET  (ALPHABET),
      .MAX_WORDS (MAX_WORDS),
      .CNT_W     (CNT_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (lane_ctrl),
      .code    (code),
      .count_q (lane_counts[p*CNT_W +: CNT_W])
    );
  end

  // Hold the item beside the lane lookup registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_ctrl <= '0;
    end else if (s_tready) begin
      a_ctrl.valid <= s_tvalid;
      a_ctrl.clear <= (s_tuser == plpa_pkg::MODE_CLEAR);
      a_ctrl.score <= (s_tuser == plpa_pkg::MODE_SCORE);
      a_ctrl.last  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_id <= in_id;
    end
  end

  // Combine the lanes and track the best candidate
  plpa_merge #(
    .WORD_LEN (WORD_LEN),
    .CNT_W    (CNT_W)
  ) u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (a_ctrl),
    .id          (a_id),
    .lane_counts (lane_counts),
    .adv         (adv),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .out_id      (out_id),
    .out_score   (out_score),
    .out_found   (m_tuser)
  );

  // Pack the result item
  assign m_tdata = {
    {(plpa_pkg::OUT_DATA_W - plpa_pkg::ID_W - plpa_pkg::SCORE_W){1'b0}},
    out_score,
    out_id
  };

endmodule

// ===== verif/plpa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plpa_checker: result checker for the positional letter profile core
// Watches both stream channels, keeps its own letter profile and running
// best candidate, and compares every result item with the oldest predicted
// pick. Mismatches, unexpected results and the backlog go to the top.
// ----------------------------------------------------------------------------
module plpa_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [plpa_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic [plpa_pkg::MODE_W-1:0]     s_tuser,
  input  logic                            s_tlast,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [plpa_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            m_tuser,
  output int                              fail_count,
  output int                              picks_waiting,
  output int                              items_seen,
  output int                              picks_checked
);

  localparam int MODE_W    = plpa_pkg::MODE_W;
  localparam int LETTERS_W = plpa_pkg::LETTERS_W;
  localparam int CODE_W    = plpa_pkg::CODE_W;
  localparam int ID_W      = plpa_pkg::ID_W;
  localparam int SCORE_W   = plpa_pkg::SCORE_W;
  localparam int WORD_LEN  = plpa_pkg::WORD_LEN_DEF;
  localparam int ALPHABET  = plpa_pkg::ALPHABET_DEF;
  localparam int MAX_WORDS = plpa_pkg::MAX_WORDS_DEF;
  localparam int TALLY_W   = $clog2(MAX_WORDS + 1);

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [SCORE_W-1:0] score;
    logic               found;
  } pick_t;

  // Own copy of the profile and the running best
  logic [TALLY_W-1:0] letter_tally [WORD_LEN][ALPHABET];
  logic [SCORE_W-1:0] lead_score;
  logic [ID_W-1:0]    lead_id;
  logic               lead_valid;

  pick_t expected_picks[$];
  int    mismatches = 0;
  int    accepted = 0;
  int    compared = 0;

  // Forget the running best candidate
  task automatic drop_lead();
    lead_score = '0;
    lead_id    = '0;
    lead_valid = 1'b0;
  endtask

  // Zero the whole profile and the running best
  task automatic wipe_profile();
    for (int pos = 0; pos < WORD_LEN; pos++) begin
      for (int code = 0; code < ALPHABET; code++) begin
        letter_tally[pos][code] = '0;
      end
    end
    drop_lead();
  endtask

  // Apply one accepted item to the profile; a last score item yields a pick
  task automatic fold_item(input logic [MODE_W-1:0] mode,
                           input logic [LETTERS_W-1:0] letters,
                           input logic [ID_W-1:0] id,
                           input logic last);
    int    code;
    int    total;
    pick_t pick;
    case (mode)
      plpa_pkg::MODE_CLEAR: begin
        wipe_profile();
      end
      plpa_pkg::MODE_COUNT: begin
        // Out-of-alphabet codes are skipped, counters stop at the ceiling
        for (int pos = 0; pos < WORD_LEN; pos++) begin
          code = letters[pos*CODE_W +: CODE_W];
          if (code < ALPHABET && letter_tally[pos][code] < MAX_WORDS) begin
            letter_tally[pos][code] = letter_tally[pos][code] + 1'b1;
          end
        end
      end
      plpa_pkg::MODE_SCORE: begin
        total = 0;
        for (int pos = 0; pos < WORD_LEN; pos++) begin
          code = letters[pos*CODE_W +: CODE_W];
          if (code < ALPHABET) begin
            total += letter_tally[pos][code];
          end
        end
        if (total > plpa_pkg::SCORE_MAX) begin
          total = plpa_pkg::SCORE_MAX;
        end
        // Strictly greater only, so the first of equal scores stays
        if (total > lead_score) begin
          lead_score = total[SCORE_W-1:0];
          lead_id    = id;
          lead_valid = 1'b1;
        end
        if (last) begin
          pick.id    = lead_valid ? lead_id : '0;
          pick.score = lead_valid ? lead_score : '0;
          pick.found = lead_valid;
          expected_picks.push_back(pick);
          drop_lead();
        end
      end
      default: begin
      end
    endcase
  endtask

  // Compare one result item with the oldest predicted pick
  task automatic check_pick(input logic [ID_W-1:0] got_id,
                            input logic [SCORE_W-1:0] got_score,
                            input logic got_found);
    pick_t want;
    if (expected_picks.size() == 0) begin
      $display("%0t: result with no pick pending: id %0d score %0d found %0d",
               $time, got_id, got_score, got_found);
      mismatches++;
    end else begin
      want = expected_picks.pop_front();
      compared++;
      if (got_id !== want.id) begin
        $display("%0t: best_word_id expected %0d, actual %0d", $time, want.id, got_id);
        mismatches++;
      end
      if (got_score !== want.score) begin
        $display("%0t: best_score expected %0d, actual %0d", $time, want.score, got_score);
        mismatches++;
      end
      if (got_found !== want.found) begin
        $display("%0t: found expected %0d, actual %0d", $time, want.found, got_found);
        mismatches++;
      end
    end
  endtask

  // Sample both channels at each edge; inputs first, then results
  always @(posedge clk) begin
    if (rst) begin
      wipe_profile();
      expected_picks.delete();
    end else begin
      if (s_tvalid && s_tready) begin
        accepted++;
        fold_item(s_tuser, s_tdata[LETTERS_W-1:0],
                  s_tdata[LETTERS_W +: ID_W], s_tlast);
      end
      if (m_tvalid && m_tready) begin
        check_pick(m_tdata[ID_W-1:0], m_tdata[ID_W +: SCORE_W], m_tuser);
      end
    end
    fail_count    <= mismatches;
    picks_waiting <= expected_picks.size();
    items_seen    <= accepted;
    picks_checked <= compared;
  end

endmodule

// ===== verif/tb_positional_letter_profile_argmax_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_positional_letter_profile_argmax_core: stimulus and verdict
// Streams clear, count, score and unused-mode items into the core with random
// gaps and result backpressure: a directed opening, a back-to-back burst, then
// random profile/scoring passes. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_positional_letter_profile_argmax_core;

  localparam int MODE_W     = plpa_pkg::MODE_W;
  localparam int LETTERS_W  = plpa_pkg::LETTERS_W;
  localparam int CODE_W     = plpa_pkg::CODE_W;
  localparam int ID_W       = plpa_pkg::ID_W;
  localparam int IN_DATA_W  = plpa_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = plpa_pkg::OUT_DATA_W;
  localparam int WORD_LEN   = plpa_pkg::WORD_LEN_DEF;
  localparam int ALPHABET   = plpa_pkg::ALPHABET_DEF;

  localparam int RANDOM_ITEMS   = 1050;
  localparam int BURST_WORDS    = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 10;
  localparam int RECENT_DEPTH   = 8;
  localparam int CODE_TOP       = (1 << CODE_W) - 1;

  localparam logic [MODE_W-1:0] MODE_CLEAR = plpa_pkg::MODE_CLEAR;
  localparam logic [MODE_W-1:0] MODE_COUNT = plpa_pkg::MODE_COUNT;
  localparam logic [MODE_W-1:0] MODE_SCORE = plpa_pkg::MODE_SCORE;
  // Mode value the core must ignore
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  logic                  clk      = 1'b0;
  logic                  rst      = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic [IN_DATA_W-1:0]  s_tdata  = '0;
  logic [MODE_W-1:0]     s_tuser  = MODE_CLEAR;
  logic                  s_tlast  = 1'b0;
  logic                  m_tready = 1'b0;
  logic                  s_tready;
  logic                  m_tvalid;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;

  int fail_count;
  int picks_waiting;
  int items_seen;
  int picks_checked;

  logic quiet       = 1'b0;
  int   sink_hold   = 0;
  int   idle_cycles = 0;
  int   items_sent  = 0;
  int   passes      = 0;
  logic [LETTERS_W-1:0] recent_words [RECENT_DEPTH];
  int   recent_next = 0;

  positional_letter_profile_argmax_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  plpa_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .s_tlast       (s_tlast),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .fail_count    (fail_count),
    .picks_waiting (picks_waiting),
    .items_seen    (items_seen),
    .picks_checked (picks_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Pack five letter codes, position 0 lowest
  function automatic logic [LETTERS_W-1:0] make_word(input logic [CODE_W-1:0] c0,
                                                     input logic [CODE_W-1:0] c1,
                                                     input logic [CODE_W-1:0] c2,
                                                     input logic [CODE_W-1:0] c3,
                                                     input logic [CODE_W-1:0] c4);
    return {c4, c3, c2, c1, c0};
  endfunction

  // Random word biased to a few letters so scores climb and ties occur
  function automatic logic [LETTERS_W-1:0] random_word();
    logic [LETTERS_W-1:0] w;
    int r;
    w = '0;
    if ($urandom_range(0, 9) == 0) return LETTERS_W'($urandom());
    for (int pos = 0; pos < WORD_LEN; pos++) begin
      r = $urandom_range(0, 99);
      if (r < 70) w[pos*CODE_W +: CODE_W] = CODE_W'($urandom_range(0, 4));
      else if (r < 94) w[pos*CODE_W +: CODE_W] = CODE_W'($urandom_range(0, ALPHABET - 1));
      else w[pos*CODE_W +: CODE_W] = CODE_W'($urandom_range(ALPHABET, CODE_TOP));
    end
    return w;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [MODE_W-1:0] mode,
                           input logic [LETTERS_W-1:0] letters,
                           input logic [ID_W-1:0] id,
                           input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_DATA_W - LETTERS_W - ID_W){1'b0}}, id, letters};
    s_tuser  <= mode;
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // Hold off the sender until every pending pick has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (picks_waiting != 0) @(posedge clk);
  endtask

  // Result sink: ready stretches and stalls of random length
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (quiet || $urandom_range(0, 99) < 60) begin
      m_tready  <= 1'b1;
      sink_hold <= quiet ? 0 : $urandom_range(0, 8);
    end else begin
      m_tready  <= 1'b0;
      sink_hold <= pick_gap();
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d picks still pending", $time, picks_waiting);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int count_len;
    int score_len;
    int noise;
    logic [LETTERS_W-1:0] word;

    for (int i = 0; i < RECENT_DEPTH; i++) begin
      recent_words[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty profile gives no pick
    send_item(MODE_SCORE, make_word(5'd0, 5'd0, 5'd0, 5'd0, 5'd0), 12'd5, 1'b1);
    // Count with last set, which must not end anything
    send_item(MODE_COUNT, make_word(5'd1, 5'd2, 5'd3, 5'd4, 5'd5), 12'd9, 1'b1);
    send_item(MODE_COUNT, make_word(5'd1, 5'd2, 5'd3, 5'd4, 5'd5), 12'd0, 1'b0);
    // Out-of-alphabet code at the top position
    send_item(MODE_COUNT, make_word(5'd1, 5'd7, 5'd3, 5'd9, 5'd30), 12'd1, 1'b0);
    // Unused mode, ignored even with last set
    send_item(MODE_UNUSED, make_word(5'd1, 5'd2, 5'd3, 5'd4, 5'd5), 12'hFFF, 1'b1);
    // Tie: the first candidate keeps the lead
    send_item(MODE_SCORE, make_word(5'd1, 5'd2, 5'd3, 5'd4, 5'd5), 12'hFFF, 1'b0);
    send_item(MODE_SCORE, make_word(5'd1, 5'd2, 5'd3, 5'd4, 5'd5), 12'h001, 1'b0);
    send_item(MODE_SCORE, make_word(5'd31, 5'd31, 5'd31, 5'd31, 5'd31), 12'h000, 1'b1);
    // Clear with every other field at its top value
    send_item(MODE_CLEAR, '1, 12'hFFF, 1'b1);
    send_item(MODE_SCORE, make_word(5'd1, 5'd2, 5'd3, 5'd4, 5'd5), 12'd7, 1'b1);
    // All-ones letters are out of alphabet and must not count
    send_item(MODE_COUNT, '1, 12'hFFF, 1'b0);
    send_item(MODE_COUNT, make_word(5'd25, 5'd25, 5'd25, 5'd25, 5'd25), 12'd2, 1'b0);
    send_item(MODE_SCORE, make_word(5'd25, 5'd25, 5'd25, 5'd25, 5'd25), 12'hABC, 1'b0);
    send_item(MODE_SCORE, make_word(5'd0, 5'd0, 5'd0, 5'd0, 5'd0), 12'd0, 1'b0);
    send_item(MODE_SCORE, '1, 12'd4, 1'b1);
    // Clear, then a winner with id zero, then a fresh pass on the kept profile
    send_item(MODE_CLEAR, '0, 12'd0, 1'b0);
    send_item(MODE_COUNT, make_word(5'd25, 5'd0, 5'd25, 5'd0, 5'd25), 12'd6, 1'b0);
    send_item(MODE_SCORE, make_word(5'd25, 5'd0, 5'd25, 5'd0, 5'd25), 12'd0, 1'b1);
    send_item(MODE_SCORE, make_word(5'd25, 5'd0, 5'd25, 5'd0, 5'd25), 12'd3, 1'b1);
    send_item(MODE_SCORE, make_word(5'd25, 5'd1, 5'd25, 5'd1, 5'd25), 12'd8, 1'b1);
    drain();

    // Burst: identical words back to back with the sink always ready
    quiet <= 1'b1;
    send_item(MODE_CLEAR, '0, 12'd0, 1'b0);
    for (int i = 0; i < BURST_WORDS; i++) begin
      send_item(MODE_COUNT, make_word(5'd0, 5'd0, 5'd0, 5'd0, 5'd0), ID_W'(i), 1'b0);
    end
    send_item(MODE_SCORE, make_word(5'd0, 5'd0, 5'd0, 5'd0, 5'd1), 12'h123, 1'b0);
    send_item(MODE_SCORE, make_word(5'd0, 5'd0, 5'd0, 5'd0, 5'd0), 12'h800, 1'b0);
    send_item(MODE_SCORE, make_word(5'd0, 5'd0, 5'd0, 5'd0, 5'd0), 12'h801, 1'b1);
    quiet <= 1'b0;
    drain();

    // Random passes: build the profile, then score a list of candidates
    while (items_sent < RANDOM_ITEMS) begin
      quiet <= ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) begin
        send_item(MODE_CLEAR, LETTERS_W'($urandom()), ID_W'($urandom()),
                  1'($urandom_range(0, 1)));
      end
      count_len = $urandom_range(0, 16);
      for (int k = 0; k < count_len; k++) begin
        word = random_word();
        recent_words[recent_next] = word;
        recent_next = (recent_next + 1) % RECENT_DEPTH;
        send_item(MODE_COUNT, word, ID_W'($urandom()), ($urandom_range(0, 3) == 0));
        if ($urandom_range(0, 19) == 0) begin
          send_item(MODE_UNUSED, LETTERS_W'($urandom()), ID_W'($urandom()),
                    1'($urandom_range(0, 1)));
        end
      end
      score_len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 10);
      for (int k = 0; k < score_len; k++) begin
        // Occasional noise inside the pass
        noise = $urandom_range(0, 39);
        if (noise == 0) begin
          send_item(MODE_CLEAR, LETTERS_W'($urandom()), ID_W'($urandom()), 1'b1);
        end else if (noise < 3) begin
          send_item(MODE_UNUSED, LETTERS_W'($urandom()), ID_W'($urandom()),
                    1'($urandom_range(0, 1)));
        end else if (noise < 5) begin
          send_item(MODE_COUNT, random_word(), ID_W'($urandom()), 1'($urandom_range(0, 1)));
        end
        word = ($urandom_range(0, 1) == 1) ? recent_words[$urandom_range(0, RECENT_DEPTH - 1)]
                                           : random_word();
        send_item(MODE_SCORE, word, ID_W'($urandom()), (k == score_len - 1));
      end
      passes++;
      if ($urandom_range(0, 7) == 0) begin
        drain();
      end
    end

    // Let the last results come back, then watch for strays
    quiet <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Summary: %0d items accepted, %0d picks compared over %0d random passes",
             items_seen, picks_checked, passes);
    $display("Summary: clear/count/score/unused modes, back-to-back burst, ties, empty passes");
    if (fail_count == 0 && picks_waiting == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
